@@ src/sactl_pkg.sv @@
`timescale 1ns / 1ps

package sactl_pkg;

    localparam int DEF_NUM_SETS    = 64;
    localparam int DEF_NUM_WAYS    = 4;
    localparam int DEF_BLOCK_BYTES = 32;

    localparam int ADDR_W = 32;
    localparam int TIME_W = 32;

    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_INVAL  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
        logic [1:0]        way_select;
        logic [TIME_W-1:0] now;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic              fill_request;
        logic [1:0]        fill_way;
        logic [ADDR_W-1:0] fill_block_address;
    } rsp_t;

    typedef struct packed {
        logic clear_row;
        logic capture;
        logic scan_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_last;
        logic is_inval;
    } status_t;

    function automatic int floor_log2(input int n);
        int r;
        int v;
        r = 0;
        v = n;
        while (v > 1)
        begin
            v = v >> 1;
            r = r + 1;
        end
        return r;
    endfunction

endpackage

@@ src/sactl_datapath.sv @@
`timescale 1ns / 1ps

module sactl_datapath #(
    parameter int NUM_SETS    = 64,
    parameter int NUM_WAYS    = 4,
    parameter int BLOCK_BYTES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sactl_pkg::req_t    req,
    input  sactl_pkg::cmd_t    cmd,
    output sactl_pkg::status_t status,
    output sactl_pkg::rsp_t    rsp
);
    import sactl_pkg::*;

    localparam int OFS_BITS  = floor_log2(BLOCK_BYTES);
    localparam int SET_BITS  = floor_log2(NUM_SETS);
    localparam int SET_IDX_W = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int MEM_DEPTH = 1 << SET_IDX_W;
    localparam int TAG_W     = ADDR_W - OFS_BITS - SET_BITS;
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

    localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'((64'd1 << SET_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] OFS_MASK = ADDR_W'((64'd1 << OFS_BITS) - 64'd1);

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] stamp;
    } line_t;

    typedef line_t [NUM_WAYS-1:0] row_t;

    row_t mem [MEM_DEPTH];

    req_t                 req_reg;
    row_t                 row_reg;
    row_t                 row_next;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;
    logic [WAY_W-1:0]     way_cnt_reg;
    logic                 hit_found_reg;
    logic [WAY_W-1:0]     hit_way_reg;
    logic [WAY_W-1:0]     victim_reg;
    logic [TIME_W-1:0]    oldest_reg;
    logic [SET_IDX_W-1:0] clr_cnt_reg;
    logic [SET_IDX_W-1:0] req_set;
    logic [SET_IDX_W-1:0] item_set;
    logic [TAG_W-1:0]     item_tag;
    line_t                cur_line;
    logic                 way_hit;

    function automatic logic [SET_IDX_W-1:0] set_of(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] s;
        s = (a >> OFS_BITS) & SET_MASK;
        return s[SET_IDX_W-1:0];
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] t;
        t = a >> (OFS_BITS + SET_BITS);
        return t[TAG_W-1:0];
    endfunction

    assign req_set  = set_of(req.address);
    assign item_set = set_of(req_reg.address);
    assign item_tag = tag_of(req_reg.address);
    assign cur_line = row_reg[way_cnt_reg];
    assign way_hit  = cur_line.valid && (cur_line.tag == item_tag);

    assign status.clear_last = (clr_cnt_reg == SET_IDX_W'(MEM_DEPTH - 1));
    assign status.scan_last  = (way_cnt_reg == WAY_W'(NUM_WAYS - 1));
    assign status.is_inval   = (req_reg.action == ACT_INVAL);
    assign rsp               = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg <= mem[req_set];
        end
        if (cmd.clear_row)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.commit)
        begin
            mem[item_set] <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            way_cnt_reg   <= '0;
            hit_found_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.clear_row)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.capture)
            begin
                way_cnt_reg   <= '0;
                hit_found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                way_cnt_reg <= way_cnt_reg + 1'b1;
                if (way_hit)
                begin
                    hit_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.scan_step)
        begin
            if (way_hit && !hit_found_reg)
            begin
                hit_way_reg <= way_cnt_reg;
            end
            if ((way_cnt_reg == '0) || (cur_line.stamp < oldest_reg))
            begin
                oldest_reg <= cur_line.stamp;
                victim_reg <= way_cnt_reg;
            end
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        row_next = row_reg;
        rsp_next = '0;
        if (req_reg.action == ACT_INVAL)
        begin
            if (int'(req_reg.way_select) < NUM_WAYS)
            begin
                row_next[WAY_W'(req_reg.way_select)] = '0;
            end
        end
        else if (hit_found_reg)
        begin
            row_next[hit_way_reg].stamp = req_reg.now;
            rsp_next.hit                = 1'b1;
        end
        else
        begin
            row_next[victim_reg].valid   = 1'b1;
            row_next[victim_reg].tag     = item_tag;
            row_next[victim_reg].stamp   = req_reg.now;
            rsp_next.fill_request        = 1'b1;
            rsp_next.fill_way            = 2'(victim_reg);
            rsp_next.fill_block_address  = req_reg.address & ~OFS_MASK;
        end
    end

endmodule

@@ src/sactl_ctrl.sv @@
`timescale 1ns / 1ps

module sactl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  sactl_pkg::status_t status,
    output sactl_pkg::cmd_t    cmd
);
    import sactl_pkg::*;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd            = '0;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_row = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.is_inval || status.scan_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

@@ src/set_assoc_cache_tag_lru.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_data (action, address, way_select, now)
// rsp       out        rsp_valid/rsp_stall  rsp_data (hit, fill_request, fill_way, ...)
//
// An access compares and ages the ways of the set row one per cycle, and a new request is
// taken only after the current one is committed; an invalidate skips the way comparison.
// After reset a clearing pass writes every set row to zero, and req_stall stays high until it
// ends.
// A finished result waits in an output register, so a stalled response does not block the
// next request transfer; only the write of the following result waits for it.

module set_assoc_cache_tag_lru #(
    parameter int NUM_SETS    = sactl_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS    = sactl_pkg::DEF_NUM_WAYS,
    parameter int BLOCK_BYTES = sactl_pkg::DEF_BLOCK_BYTES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  sactl_pkg::req_t req_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output sactl_pkg::rsp_t rsp_data
);
    import sactl_pkg::*;

    cmd_t    cmd;
    status_t status;

    sactl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sactl_datapath #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_data),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp_data)
    );

    a_commit_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(rsp_valid && rsp_stall))
        else $error("Result written over a response still waiting.");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("Second request taken while one is in work.");

    a_hit_or_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.hit && rsp_data.fill_request))
        else $error("Response reports both a hit and a fill.");

    a_no_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.fill_request) |->
            (rsp_data.fill_way == 2'd0 && rsp_data.fill_block_address == '0))
        else $error("Fill fields set without a fill request.");

endmodule
